FILE: src/lsem_pkg.sv
package lsem_pkg;

	// Fixed field widths
	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_W       = 32;
	localparam int DATA_W       = 32;
	localparam int PROD_W       = COEF_W + DATA_W;
	localparam int ACC_W        = 64;
	localparam int PEAK_W       = 31;
	localparam int CHAN_W       = 3;
	localparam int CFG_IDX_W    = 4;
	localparam int STEP_W       = 4;
	localparam int CHANNELS_DEF = 8;

	// One history word per channel: x1, x2, y1, y2, e1, e2
	localparam int HIST_W = 2 * SAMPLE_BITS + 4 * DATA_W;

	// 1.0 in sample units and the output sample limits
	localparam longint ONE_L  = longint'(1) << (SAMPLE_BITS - 1);
	localparam longint SMAX_L = ONE_L - 1;
	localparam longint SMIN_L = -ONE_L;

	// Rounding offset before the final shift
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd8388608);
	localparam int FIN_SHIFT = 24;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_sample;
		logic [CHAN_W-1:0]             channel;
		logic                          chunk_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic signed [DATA_W-1:0]      excursion;
		logic [PEAK_W-1:0]             peak;
		logic                          over_limit;
	} out_item_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EQ_A1     = 4'd0,
		REG_EQ_A2     = 4'd1,
		REG_EQ_B0     = 4'd2,
		REG_EQ_B1     = 4'd3,
		REG_EQ_B2     = 4'd4,
		REG_MECH_A1   = 4'd5,
		REG_MECH_A2   = 4'd6,
		REG_MECH_GAIN = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] eq_a1;
		logic signed [COEF_W-1:0] eq_a2;
		logic signed [COEF_W-1:0] eq_b0;
		logic signed [COEF_W-1:0] eq_b1;
		logic signed [COEF_W-1:0] eq_b2;
		logic signed [COEF_W-1:0] mech_a1;
		logic signed [COEF_W-1:0] mech_a2;
		logic signed [COEF_W-1:0] mech_gain;
	} coef_t;

	// Microcode fields
	typedef enum logic [2:0] {
		SEL_X0, SEL_X1, SEL_X2, SEL_Y0, SEL_Y1, SEL_Y2, SEL_E1, SEL_E2
	} data_sel_t;

	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

	typedef enum logic [1:0] {FIN_NONE, FIN_EQ, FIN_EXC} fin_t;

	typedef enum logic [1:0] {COND_NEXT, COND_IN, COND_OUT} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_HOME = '0;

	typedef struct packed {
		cond_t     cond;
		step_t     target;
		reg_idx_t  coef;
		data_sel_t data;
		acc_op_t   acc;
		logic      half;
		fin_t      fin;
		logic      load_hist;
		logic      emit;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic out_free;
	} seq_status_t;

	// Control store: one word per step. A product issued at step n is
	// accumulated at step n+1.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{cond: COND_NEXT, target: STEP_HOME, coef: REG_EQ_B0, data: SEL_X0,
			acc: ACC_HOLD, half: 1'b0, fin: FIN_NONE, load_hist: 1'b0, emit: 1'b0};
		case (s)
			4'd0: begin
				w.cond = COND_IN;
			end
			4'd1: begin
				w.load_hist = 1'b1;
				w.coef = REG_EQ_B0;
				w.data = SEL_X0;
			end
			4'd2: begin
				w.coef = REG_EQ_B1;
				w.data = SEL_X1;
				w.acc = ACC_LOAD;
			end
			4'd3: begin
				w.coef = REG_EQ_B2;
				w.data = SEL_X2;
				w.acc = ACC_ADD;
			end
			4'd4: begin
				w.coef = REG_EQ_A1;
				w.data = SEL_Y1;
				w.acc = ACC_ADD;
			end
			4'd5: begin
				w.coef = REG_EQ_A2;
				w.data = SEL_Y2;
				w.acc = ACC_SUB;
			end
			4'd6: begin
				w.acc = ACC_SUB;
			end
			4'd7: begin
				w.fin = FIN_EQ;
			end
			4'd8: begin
				w.coef = REG_MECH_GAIN;
				w.data = SEL_Y0;
			end
			4'd9: begin
				w.coef = REG_MECH_GAIN;
				w.data = SEL_Y1;
				w.acc = ACC_LOAD;
			end
			4'd10: begin
				w.coef = REG_MECH_GAIN;
				w.data = SEL_Y2;
				w.acc = ACC_ADD;
				w.half = 1'b1;
			end
			4'd11: begin
				w.coef = REG_MECH_A1;
				w.data = SEL_E1;
				w.acc = ACC_ADD;
			end
			4'd12: begin
				w.coef = REG_MECH_A2;
				w.data = SEL_E2;
				w.acc = ACC_SUB;
			end
			4'd13: begin
				w.acc = ACC_SUB;
			end
			4'd14: begin
				w.fin = FIN_EXC;
			end
			4'd15: begin
				w.cond = COND_OUT;
				w.target = STEP_HOME;
				w.emit = 1'b1;
			end
			default: begin
				w.cond = COND_NEXT;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: src/loudspeaker_eq_with_excursion_monitor.sv
// Per-channel loudspeaker equalizer with cone-excursion monitor. Each input
// transaction carries a Q1.23 sample and a channel tag (tags at or above
// CHANNELS wrap); each produces exactly one result: the equalized sample,
// the modelled excursion, the running peak of its magnitude across all
// channels and an over-limit flag for peak above 1.0. A transaction marked
// chunk_end clears the peak after its result is formed. The result register
// loads at the last step of the program, at the same edge that returns it
// home; no new item starts until then. A 16-step microprogram runs ten
// products through a single 32x32 multiplier and accumulator, including a
// step for the registered history read. The next input is taken as soon
// as the program returns home, even while the previous result waits to be
// taken; a result stalls the program only if the one before it is still held.
// Channel history starts at zero after reset through per-channel valid bits,
// so there is no clearing pass. Coefficients (Q4.28) are written through the
// configuration port and must only change while the block is idle.
module loudspeaker_eq_with_excursion_monitor #(
	parameter int CHANNELS = lsem_pkg::CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lsem_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lsem_pkg::out_item_t              out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lsem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsem_pkg::COEF_W-1:0]      cfg_data
);

	import lsem_pkg::*;

	coef_t coef_q;
	ctrl_t ctrl;
	seq_status_t status;

	assign cfg_ready = 1'b1;

	// Coefficient registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{eq_a1: '0, eq_a2: '0, eq_b0: COEF_W'(32'h1000_0000),
				eq_b1: '0, eq_b2: '0, mech_a1: '0, mech_a2: '0, mech_gain: '0};
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_EQ_A1:     coef_q.eq_a1     <= cfg_data;
				REG_EQ_A2:     coef_q.eq_a2     <= cfg_data;
				REG_EQ_B0:     coef_q.eq_b0     <= cfg_data;
				REG_EQ_B1:     coef_q.eq_b1     <= cfg_data;
				REG_EQ_B2:     coef_q.eq_b2     <= cfg_data;
				REG_MECH_A1:   coef_q.mech_a1   <= cfg_data;
				REG_MECH_A2:   coef_q.mech_a2   <= cfg_data;
				REG_MECH_GAIN: coef_q.mech_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	lsem_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl)
	);

	lsem_dp #(
		.CHANNELS(CHANNELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.coef     (coef_q),
		.ctrl     (ctrl),
		.status   (status)
	);

endmodule

FILE: src/lsem_ram.sv
module lsem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/lsem_seq.sv
module lsem_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsem_pkg::seq_status_t status,
	output lsem_pkg::ctrl_t       ctrl
);

	import lsem_pkg::*;

	step_t step_q;

	// Fetch the control word of the current step
	assign ctrl = ucode(step_q);

	// Advance, hold on a wait, or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_HOME;
		end else begin
			case (ctrl.cond)
				COND_IN: begin
					if (status.in_fire) begin
						step_q <= step_q + 1'b1;
					end
				end
				COND_OUT: begin
					if (status.out_free) begin
						step_q <= ctrl.target;
					end
				end
				default: begin
					step_q <= step_q + 1'b1;
				end
			endcase
		end
	end

	// A transaction is taken only at the home step
	a_fire_home: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_fire |-> step_q == STEP_HOME)
		else $error("input taken away from home step");

endmodule

FILE: src/lsem_dp.sv
module lsem_dp #(
	parameter int CHANNELS = lsem_pkg::CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lsem_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lsem_pkg::out_item_t   out_item,
	input  lsem_pkg::coef_t       coef,
	input  lsem_pkg::ctrl_t       ctrl,
	output lsem_pkg::seq_status_t status
);

	import lsem_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic in_fire;
	logic out_free;
	logic emit_fire;
	logic [5:0] ch_wrap;
	logic [CW-1:0] ch;

	logic [CW-1:0] ch_q;
	logic hv_q;
	logic chunk_q;
	logic [CHANNELS-1:0] hvalid_q;

	logic signed [SAMPLE_BITS-1:0] x0_q, x1_q, x2_q;
	logic signed [DATA_W-1:0] y0_q, y1_q, y2_q, e0_q, e1_q, e2_q;

	logic [HIST_W-1:0] hist_rd;
	logic [HIST_W-1:0] hist_wr;

	logic signed [COEF_W-1:0] coef_m;
	logic signed [DATA_W-1:0] data_m;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd;
	logic signed [DATA_W-1:0] fin_sat;

	logic [DATA_W:0] mag_w;
	logic [PEAK_W-1:0] mag;
	logic [PEAK_W-1:0] peak_new;
	logic [PEAK_W-1:0] peak_q;
	logic signed [SAMPLE_BITS-1:0] out_sat;
	out_item_t out_q;
	logic out_valid_q;

	// Handshake
	assign in_ready  = (ctrl.cond == COND_IN);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = ctrl.emit && out_free;
	assign status    = '{in_fire: in_fire, out_free: out_free};

	// Wrap the channel tag into range
	always_comb begin
		ch_wrap = 6'(in_item.channel);
		for (int k = 0; k < 8; k++) begin
			if (ch_wrap >= 6'(CHANNELS)) begin
				ch_wrap = ch_wrap - 6'(CHANNELS);
			end
		end
		ch = ch_wrap[CW-1:0];
	end

	// Per-channel history memory
	assign hist_wr = {x0_q, x1_q, y0_q, y1_q, e0_q, e1_q};

	lsem_ram #(
		.WIDTH(HIST_W),
		.DEPTH(CHANNELS)
	) u_hist (
		.clk  (clk),
		.we   (emit_fire),
		.waddr(ch_q),
		.wdata(hist_wr),
		.raddr(ch),
		.rdata(hist_rd)
	);

	// Operand selection for the shared multiplier
	always_comb begin
		case (ctrl.coef)
			REG_EQ_A1:     coef_m = coef.eq_a1;
			REG_EQ_A2:     coef_m = coef.eq_a2;
			REG_EQ_B0:     coef_m = coef.eq_b0;
			REG_EQ_B1:     coef_m = coef.eq_b1;
			REG_EQ_B2:     coef_m = coef.eq_b2;
			REG_MECH_A1:   coef_m = coef.mech_a1;
			REG_MECH_A2:   coef_m = coef.mech_a2;
			REG_MECH_GAIN: coef_m = coef.mech_gain;
			default:       coef_m = '0;
		endcase
		case (ctrl.data)
			SEL_X0:  data_m = DATA_W'(x0_q);
			SEL_X1:  data_m = DATA_W'(x1_q);
			SEL_X2:  data_m = DATA_W'(x2_q);
			SEL_Y0:  data_m = y0_q;
			SEL_Y1:  data_m = y1_q;
			SEL_Y2:  data_m = y2_q;
			SEL_E1:  data_m = e1_q;
			SEL_E2:  data_m = e2_q;
			default: data_m = '0;
		endcase
	end

	// Scale the product: the doubled middle tap drops one bit less
	assign term = ctrl.half ? (ACC_W'(prod_s1) >>> 3) : (ACC_W'(prod_s1) >>> 4);

	// Round half up, drop the fraction, saturate to 32 bits
	always_comb begin
		rnd = (acc_q + RND_HALF) >>> FIN_SHIFT;
		if (rnd > ACC_W'(64'sd2147483647)) begin
			fin_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (rnd < -ACC_W'(64'sd2147483648)) begin
			fin_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			fin_sat = rnd[DATA_W-1:0];
		end
	end

	// Peak tracking and output sample saturation
	always_comb begin
		mag_w = e0_q[DATA_W-1] ? -(DATA_W+1)'(e0_q) : (DATA_W+1)'(e0_q);
		mag = mag_w[DATA_W-1] ? {PEAK_W{1'b1}} : mag_w[PEAK_W-1:0];
		peak_new = (mag > peak_q) ? mag : peak_q;
		if (64'(y0_q) > SMAX_L) begin
			out_sat = SAMPLE_BITS'(SMAX_L);
		end else if (64'(y0_q) < SMIN_L) begin
			out_sat = SAMPLE_BITS'(SMIN_L);
		end else begin
			out_sat = y0_q[SAMPLE_BITS-1:0];
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x0_q    <= in_item.in_sample;
			chunk_q <= in_item.chunk_end;
			ch_q    <= ch;
			hv_q    <= hvalid_q[ch];
		end
		if (ctrl.load_hist) begin
			{x1_q, x2_q, y1_q, y2_q, e1_q, e2_q} <= hv_q ? hist_rd : '0;
		end
		prod_s1 <= coef_m * data_m;
		case (ctrl.acc)
			ACC_LOAD: acc_q <= term;
			ACC_ADD:  acc_q <= acc_q + term;
			ACC_SUB:  acc_q <= acc_q - term;
			default:  acc_q <= acc_q;
		endcase
		case (ctrl.fin)
			FIN_EQ:  y0_q <= fin_sat;
			FIN_EXC: e0_q <= fin_sat;
			default: ;
		endcase
		if (emit_fire) begin
			out_q <= '{out_sample: out_sat, excursion: e0_q, peak: peak_new,
				over_limit: (64'(peak_new) > ONE_L)};
		end
	end

	// Control state: output valid, running peak, history valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			peak_q      <= '0;
			hvalid_q    <= '0;
		end else begin
			if (emit_fire) begin
				out_valid_q  <= 1'b1;
				peak_q       <= chunk_q ? '0 : peak_new;
				hvalid_q[ch_q] <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Flag agrees with the reported peak
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.over_limit == (64'(out_q.peak) > ONE_L)))
		else $error("over_limit disagrees with peak");

	// Peak only grows within a chunk
	a_peak_up: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && !chunk_q) |=> (peak_q >= $past(peak_q)))
		else $error("peak dropped inside a chunk");

	// Reported peak covers the reported excursion magnitude
	a_peak_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.excursion[DATA_W-1])
		|-> (DATA_W'(out_q.peak) >= out_q.excursion))
		else $error("peak below excursion");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import lsem_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 10;
	localparam int NUM_REGS     = int'(REG_MECH_GAIN) + 1;
	localparam int RAND_ITEMS   = 1950;
	localparam int CALM_ITEMS   = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int SETTLE       = 24;
	localparam int DRAIN_WAIT   = 48;
	localparam int WATCHDOG     = 4000;

	// Directed coefficient sets
	localparam int SET_RESET   = 0;
	localparam int SET_MAX     = 1;
	localparam int SET_MIN     = 2;
	localparam int SET_RUNAWAY = 3;
	localparam int SET_MONITOR = 4;
	localparam int NUM_SETS    = 5;

	localparam int S_MAX = 8388607;
	localparam int S_MIN = -8388608;

	typedef struct {
		int        set_id;
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [COEF_W-1:0]     cfg_data;

	// Predictor state
	int     coef_m [NUM_REGS];
	int     x_h1 [CHANNELS_DEF];
	int     x_h2 [CHANNELS_DEF];
	int     y_h1 [CHANNELS_DEF];
	int     y_h2 [CHANNELS_DEF];
	int     e_h1 [CHANNELS_DEF];
	int     e_h2 [CHANNELS_DEF];
	longint peak_m;

	out_item_t pending_results [$];
	dir_row_t  dir_rows [$];
	int        dir_coef [NUM_SETS][NUM_REGS];
	int        phase_coef [NUM_REGS];

	int        mismatches = 0;
	int        results_taken = 0;
	int        quiet_cycles = 0;
	bit        calm = 1'b0;
	bit        hold_done = 1'b0;
	out_item_t oldest;

	loudspeaker_eq_with_excursion_monitor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Exact product, then floor shift
	function automatic longint prod_sh(int c, int d, int s);
		return (longint'(c) * longint'(d)) >>> s;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Round half up while dropping the fraction bits
	function automatic longint round_q(longint acc);
		return (acc + (longint'(1) << (FIN_SHIFT - 1))) >>> FIN_SHIFT;
	endfunction

	// Run both biquads for one sample and update the channel history and peak
	function automatic out_item_t equalize_and_monitor(in_item_t it);
		int        ch, x0, x1, x2, y1, y2, e1, e2;
		longint    y0, e0, mag, s;
		out_item_t r;
		ch = int'(it.channel) % CHANNELS_DEF;
		x0 = {{(32 - SAMPLE_BITS){it.in_sample[SAMPLE_BITS-1]}}, it.in_sample};
		x1 = x_h1[ch];
		x2 = x_h2[ch];
		y1 = y_h1[ch];
		y2 = y_h2[ch];
		e1 = e_h1[ch];
		e2 = e_h2[ch];

		y0 = clip(round_q(prod_sh(coef_m[REG_EQ_B0], x0, 4) + prod_sh(coef_m[REG_EQ_B1], x1, 4)
			+ prod_sh(coef_m[REG_EQ_B2], x2, 4) - prod_sh(coef_m[REG_EQ_A1], y1, 4)
			- prod_sh(coef_m[REG_EQ_A2], y2, 4)), 32);
		e0 = clip(round_q(prod_sh(coef_m[REG_MECH_GAIN], int'(y0), 4)
			+ prod_sh(coef_m[REG_MECH_GAIN], y1, 3) + prod_sh(coef_m[REG_MECH_GAIN], y2, 4)
			- prod_sh(coef_m[REG_MECH_A1], e1, 4) - prod_sh(coef_m[REG_MECH_A2], e2, 4)), 32);

		x_h2[ch] = x1;
		x_h1[ch] = x0;
		y_h2[ch] = y1;
		y_h1[ch] = int'(y0);
		e_h2[ch] = e1;
		e_h1[ch] = int'(e0);

		// Magnitude of the most negative excursion saturates
		mag = (e0 < 0) ? -e0 : e0;
		if (mag > 64'sd2147483647)
			mag = 64'sd2147483647;
		if (mag > peak_m)
			peak_m = mag;

		s = clip(y0, SAMPLE_BITS);
		r.out_sample = s[SAMPLE_BITS-1:0];
		r.excursion  = e0[DATA_W-1:0];
		r.peak       = peak_m[PEAK_W-1:0];
		r.over_limit = (peak_m > ONE_L);
		if (it.chunk_end)
			peak_m = 0;
		return r;
	endfunction

	function automatic int pick_gap(bit noisy);
		if (noisy && $urandom_range(0, 3) == 0)
			return $urandom_range(1, 17);
		return 0;
	endfunction

	function automatic void add_row(int set_id, int sample, int ch, bit ce, bit typed,
		int w_s = 0, int w_e = 0, int w_p = 0, bit w_o = 1'b0);
		dir_row_t row;
		row.set_id          = set_id;
		row.item.in_sample  = sample[SAMPLE_BITS-1:0];
		row.item.channel    = ch[CHAN_W-1:0];
		row.item.chunk_end  = ce;
		row.typed           = typed;
		row.want.out_sample = w_s[SAMPLE_BITS-1:0];
		row.want.excursion  = w_e;
		row.want.peak       = w_p[PEAK_W-1:0];
		row.want.over_limit = w_o;
		dir_rows.push_back(row);
	endfunction

	// Offer one transaction; leave valid high unless a gap follows
	task automatic send(in_item_t it, bit typed, out_item_t want, int gap);
		out_item_t got;
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = equalize_and_monitor(it);
		pending_results.push_back(typed ? want : got);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= REG_MECH_GAIN)
			coef_m[idx] = data;
	endtask

	// Write every register, then one index past the list that must be dropped
	task automatic load_coefs(input int vals [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(CFG_IDX_W'(i), vals[i]);
		write_reg(CFG_IDX_W'(int'(REG_MECH_GAIN) + 1 + $urandom_range(0, 7)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Drain all outstanding results before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_taken++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_sample %0d excursion %0d", out_item.out_sample,
					out_item.excursion);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				if (out_item.out_sample !== oldest.out_sample) begin
					$error("out_sample: expected %0d, actual %0d", oldest.out_sample,
						out_item.out_sample);
					mismatches++;
				end
				if (out_item.excursion !== oldest.excursion) begin
					$error("excursion: expected %0d, actual %0d", oldest.excursion,
						out_item.excursion);
					mismatches++;
				end
				if (out_item.peak !== oldest.peak) begin
					$error("peak: expected %0d, actual %0d", oldest.peak, out_item.peak);
					mismatches++;
				end
				if (out_item.over_limit !== oldest.over_limit) begin
					$error("over_limit: expected %0d, actual %0d", oldest.over_limit,
						out_item.over_limit);
					mismatches++;
				end
			end
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off, steady near the end
	initial begin
		bit steady;
		int span;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			steady = calm || ($urandom_range(0, 2) == 0);
			span   = $urandom_range(20, 200);
			repeat (span) begin
				if (!hold_done && results_taken >= HOLD_AFTER) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end else if (!steady && !calm && $urandom_range(0, 5) == 0) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 17)) @(posedge clk);
				end else begin
					out_ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	// Stimulus
	initial begin
		in_item_t it;
		int       cur_set;
		int       n;
		int       sent_rand;
		int       k;
		bit       noisy;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		// Coefficient sets for the directed part
		for (int s = 0; s < NUM_SETS; s++)
			for (int i = 0; i < NUM_REGS; i++)
				dir_coef[s][i] = 0;
		dir_coef[SET_RESET][REG_EQ_B0] = 1 << 28;
		for (int i = 0; i < NUM_REGS; i++) begin
			dir_coef[SET_MAX][i] = 32'h7FFF_FFFF;
			dir_coef[SET_MIN][i] = 32'h8000_0000;
		end
		dir_coef[SET_RUNAWAY][REG_EQ_B0]     = 1 << 28;
		dir_coef[SET_RUNAWAY][REG_EQ_A1]     = 32'h8000_0000;
		dir_coef[SET_RUNAWAY][REG_MECH_GAIN] = 32'h7FFF_FFFF;
		dir_coef[SET_RUNAWAY][REG_MECH_A1]   = 32'h8000_0000;
		dir_coef[SET_MONITOR][REG_EQ_B0]     = 1 << 28;
		dir_coef[SET_MONITOR][REG_MECH_GAIN] = 1 << 28;

		// After reset: unity equalizer, monitor disabled
		add_row(SET_RESET, S_MAX, 0, 1'b0, 1'b1, S_MAX, 0, 0, 1'b0);
		add_row(SET_RESET, S_MIN, 7, 1'b1, 1'b1, S_MIN, 0, 0, 1'b0);
		add_row(SET_RESET, 0,     3, 1'b0, 1'b1, 0,     0, 0, 1'b0);
		add_row(SET_RESET, -1,    0, 1'b0, 1'b1, -1,    0, 0, 1'b0);
		// Peak build-up above 1.0, clear at chunk end
		add_row(SET_MONITOR, S_MAX, 1, 1'b0, 1'b0);
		add_row(SET_MONITOR, S_MAX, 1, 1'b0, 1'b0);
		add_row(SET_MONITOR, S_MAX, 1, 1'b0, 1'b0);
		add_row(SET_MONITOR, S_MAX, 1, 1'b1, 1'b0);
		add_row(SET_MONITOR, S_MIN, 2, 1'b0, 1'b0);
		add_row(SET_MONITOR, S_MIN, 2, 1'b0, 1'b0);
		add_row(SET_MONITOR, 0,     1, 1'b0, 1'b0);
		// Runaway feedback: saturate both filters, most negative excursion
		add_row(SET_RUNAWAY, S_MIN, 5, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MIN, 5, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MIN, 5, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MIN, 5, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MIN, 5, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MAX, 6, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MAX, 6, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MAX, 6, 1'b0, 1'b0);
		add_row(SET_RUNAWAY, S_MIN, 5, 1'b1, 1'b0);
		// Extreme coefficients
		add_row(SET_MAX, S_MAX, 0, 1'b0, 1'b0);
		add_row(SET_MAX, S_MIN, 0, 1'b0, 1'b0);
		add_row(SET_MIN, S_MAX, 4, 1'b0, 1'b0);
		add_row(SET_MIN, S_MIN, 4, 1'b0, 1'b0);
		add_row(SET_MIN, 0,     4, 1'b1, 1'b0);

		// Predictor starts from the reset state
		coef_m = dir_coef[SET_RESET];
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			x_h1[c] = 0;
			x_h2[c] = 0;
			y_h1[c] = 0;
			y_h2[c] = 0;
			e_h1[c] = 0;
			e_h2[c] = 0;
		end
		peak_m = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		cur_set = SET_RESET;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].set_id != cur_set) begin
				settle();
				load_coefs(dir_coef[dir_rows[r].set_id]);
				cur_set = dir_rows[r].set_id;
			end
			send(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want, pick_gap(1'b1));
		end

		// Random phases, each with its own coefficient setting
		sent_rand = 0;
		while (sent_rand < RAND_ITEMS) begin
			n = $urandom_range(60, 250);
			if (n > RAND_ITEMS - sent_rand)
				n = RAND_ITEMS - sent_rand;
			for (int i = 0; i < NUM_REGS; i++) begin
				k = $urandom_range(0, 9);
				case (k)
					0: phase_coef[i] = 0;
					1: phase_coef[i] = 32'h7FFF_FFFF;
					2: phase_coef[i] = 32'h8000_0000;
					3: phase_coef[i] = $urandom;
					default: phase_coef[i] = int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
				endcase
			end
			settle();
			load_coefs(phase_coef);
			noisy = ($urandom_range(0, 2) != 0);
			repeat (n) begin
				k = $urandom_range(0, 7);
				case (k)
					0: it.in_sample = S_MAX[SAMPLE_BITS-1:0];
					1: it.in_sample = S_MIN[SAMPLE_BITS-1:0];
					2: it.in_sample = '0;
					3, 4: it.in_sample = SAMPLE_BITS'($urandom);
					default: it.in_sample = SAMPLE_BITS'($urandom_range(0, 131071) - 65536);
				endcase
				it.channel   = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
				it.chunk_end = ($urandom_range(0, 15) == 0);
				calm = (sent_rand >= RAND_ITEMS - CALM_ITEMS);
				send(it, 1'b0, '0, pick_gap(noisy && !calm));
				sent_rand++;
			end
		end

		// Wait out the last results, then watch for strays
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
